// ===== hdl/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

    // Pool geometry
    localparam int MAX_FRAMES = 4096;
    localparam int MAP_BYTES  = MAX_FRAMES / 8;
    localparam int ADDR_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int GRP_W      = $clog2(MAP_BYTES + 1);
    localparam int SPAN_W     = GRP_W + 3;

    // Field widths
    localparam int FRAME_W    = 20;
    localparam int RUN_W      = FRAME_W + 1;
    localparam int GROUPS_W   = 10;
    localparam int COUNT_W    = 13;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_BASE   = 1'b0;
    localparam logic CFG_GROUPS = 1'b1;

    localparam logic [7:0] BYTE_FULL = 8'hFF;
    localparam logic [7:0] BIT_ONE   = 8'h01;

    // One access to the used map
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } map_req_t;

endpackage

`default_nettype wire

// ===== hdl/bfa_map.sv =====
`default_nettype none

module bfa_map (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bfa_pkg::map_req_t req,
    output logic [7:0]           rdata,
    output logic                 busy
);
    import bfa_pkg::*;

    logic [7:0]        mem [MAP_BYTES];
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] clr_idx_reg;
    logic [ADDR_W-1:0] clr_idx_next;
    logic              busy_reg;
    logic              busy_next;

    // Sweep zeros through every byte after reset
    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == ADDR_W'(MAP_BYTES - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_idx_reg <= clr_idx_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

`default_nettype wire

// ===== hdl/bitmap_frame_allocator_unit.sv =====
`default_nettype none
// Steps from acceptance to result: allocate reads map bytes in turn up to and including the
// first byte with a free frame (every pool byte when none is free); release reads and, inside
// the pool, rewrites its frame's byte; mark does so for each frame inside the pool, skips the rest.
// Throughput: one item at a time, the next taken in the cycle after the result is loaded; the
// result then waits in an output register. The single-port used-map memory sets the pace.
// Reset: async, active low; a clearing pass over every map byte blocks items; config writes always taken.

module bitmap_frame_allocator_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_index,
    input  wire logic [bfa_pkg::FRAME_W-1:0]    cfg_data,
    // Request channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [bfa_pkg::OP_W-1:0]       op,
    input  wire logic [bfa_pkg::FRAME_W-1:0]    frame_no,
    input  wire logic [bfa_pkg::COUNT_W-1:0]    count,
    // Result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [bfa_pkg::FRAME_W-1:0]         frame_no_out,
    output logic [bfa_pkg::STATUS_W-1:0]        status
);
    import bfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_RUN_CHK,
        S_RUN_WR,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;

    // Configuration
    logic [FRAME_W-1:0]  base_reg, base_next;
    logic [GROUPS_W-1:0] groups_reg, groups_next;

    // Working registers of the current item
    logic                clear_reg, clear_next;      // release clears, mark sets
    logic [RUN_W-1:0]    cur_reg, cur_next;          // current frame of a run, no wrap
    logic [COUNT_W-1:0]  rem_reg, rem_next;          // frames left in the run
    logic                skip_reg, skip_next;        // some frame fell outside
    logic [GRP_W-1:0]    grp_reg, grp_next;          // byte under scan for allocate

    // Pending result and output register
    logic [FRAME_W-1:0]  res_frame_reg, res_frame_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0]  out_frame_reg, out_frame_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    // Map access
    map_req_t            map_req;
    logic [7:0]          map_rdata;
    logic                map_busy;

    // Pool bounds
    logic [GRP_W-1:0]    groups_live;
    logic [SPAN_W-1:0]   span;
    logic [RUN_W-1:0]    diff;
    logic                in_pool;
    logic [ADDR_W+2:0]   off;
    logic [7:0]          bit_mask;

    // Lowest clear bit of the scanned byte
    logic [2:0]          free_bit;
    logic [ADDR_W+2:0]   alloc_off;

    bfa_map u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (map_req),
        .rdata (map_rdata),
        .busy  (map_busy)
    );

    // Clamp an oversized pool to the map size
    always_comb
    begin
        if (32'(groups_reg) > MAP_BYTES)
        begin
            groups_live = GRP_W'(MAP_BYTES);
        end
        else
        begin
            groups_live = GRP_W'(groups_reg);
        end
    end

    assign span     = {groups_live, 3'b000};
    assign diff     = cur_reg - {1'b0, base_reg};
    assign in_pool  = (cur_reg >= {1'b0, base_reg}) && (diff < RUN_W'(span));
    assign off      = diff[ADDR_W+2:0];
    assign bit_mask = BIT_ONE << off[2:0];

    always_comb
    begin
        free_bit = 3'd7;
        for (int b = 7; b >= 0; b--)
        begin
            if (!map_rdata[b])
            begin
                free_bit = 3'(b);
            end
        end
    end

    assign alloc_off = {grp_reg[ADDR_W-1:0], free_bit};

    // Drive the map: the allocator scans by byte, runs address by frame offset
    always_comb
    begin
        map_req.we    = 1'b0;
        map_req.addr  = off[ADDR_W+2:3];
        map_req.wdata = map_rdata;
        unique case (state_reg)
            S_ALLOC_RD, S_ALLOC_CHK:
            begin
                map_req.addr = grp_reg[ADDR_W-1:0];
                if (state_reg == S_ALLOC_CHK && map_rdata != BYTE_FULL)
                begin
                    map_req.we    = 1'b1;
                    map_req.wdata = map_rdata | (BIT_ONE << free_bit);
                end
            end
            S_RUN_WR:
            begin
                map_req.we = 1'b1;
                if (clear_reg)
                begin
                    map_req.wdata = map_rdata & ~bit_mask;
                end
                else
                begin
                    map_req.wdata = map_rdata | bit_mask;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && !map_busy;

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        groups_next     = groups_reg;
        clear_next      = clear_reg;
        cur_next        = cur_reg;
        rem_next        = rem_reg;
        skip_next       = skip_reg;
        grp_next        = grp_reg;
        res_frame_next  = res_frame_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_frame_next  = out_frame_reg;
        out_status_next = out_status_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BASE:   base_next   = cfg_data;
                CFG_GROUPS: groups_next = cfg_data[GROUPS_W-1:0];
                default:    base_next   = base_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cur_next        = {1'b0, frame_no};
                    skip_next       = 1'b0;
                    grp_next        = '0;
                    res_frame_next  = '0;
                    res_status_next = ST_OK;
                    unique case (op)
                        OP_ALLOC:
                        begin
                            state_next = S_ALLOC_RD;
                        end
                        OP_RELEASE:
                        begin
                            clear_next = 1'b1;
                            rem_next   = COUNT_W'(1);
                            state_next = S_RUN_CHK;
                        end
                        OP_MARK:
                        begin
                            clear_next = 1'b0;
                            rem_next   = count;
                            state_next = S_RUN_CHK;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_ALLOC_RD:
            begin
                // Read of byte grp_reg issued here unless the pool is exhausted
                if (grp_reg >= groups_live)
                begin
                    res_status_next = ST_EMPTY;
                    state_next      = S_FINISH;
                end
                else
                begin
                    state_next = S_ALLOC_CHK;
                end
            end
            S_ALLOC_CHK:
            begin
                if (map_rdata != BYTE_FULL)
                begin
                    res_frame_next = base_reg + FRAME_W'(alloc_off);
                    state_next     = S_FINISH;
                end
                else
                begin
                    grp_next   = grp_reg + 1'b1;
                    state_next = S_ALLOC_RD;
                end
            end
            S_RUN_CHK:
            begin
                if (rem_reg == '0)
                begin
                    res_status_next = skip_reg ? ST_OUTSIDE : ST_OK;
                    state_next      = S_FINISH;
                end
                else if (in_pool)
                begin
                    state_next = S_RUN_WR;
                end
                else
                begin
                    skip_next = 1'b1;
                    cur_next  = cur_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                end
            end
            S_RUN_WR:
            begin
                cur_next   = cur_reg + 1'b1;
                rem_next   = rem_reg - 1'b1;
                state_next = S_RUN_CHK;
            end
            S_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_frame_next  = res_frame_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            groups_reg    <= GROUPS_W'(512);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            groups_reg    <= groups_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clear_reg      <= clear_next;
        cur_reg        <= cur_next;
        rem_reg        <= rem_next;
        skip_reg       <= skip_next;
        grp_reg        <= grp_next;
        res_frame_reg  <= res_frame_next;
        res_status_reg <= res_status_next;
        out_frame_reg  <= out_frame_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid    = out_valid_reg;
    assign frame_no_out = out_frame_reg;
    assign status       = out_status_reg;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import bfa_pkg::*;

    // Op code 3 has no name in the package; the block answers it with frame 0 and status ST_OK
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int REPORT_LIMIT = 40;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 160;

    typedef struct {
        logic [FRAME_W-1:0]  frame;
        logic [STATUS_W-1:0] status;
    } frame_result_t;

    // Shadow copy of the pool: bitmap, registers and the results still owed by the block
    class frame_pool_scoreboard;
        logic [7:0]          used_map [MAP_BYTES];
        logic [FRAME_W-1:0]  base_frame;
        logic [GROUPS_W-1:0] pool_groups;
        frame_result_t       expected_results [$];
        int                  mismatches;

        function new();
            foreach (used_map[i])
                used_map[i] = 8'h00;
            base_frame  = '0;
            pool_groups = GROUPS_W'(MAP_BYTES);
            mismatches  = 0;
        endfunction

        // An oversized group count is clamped to the map size
        function int unsigned live_groups();
            return (pool_groups > MAP_BYTES) ? MAP_BYTES : pool_groups;
        endfunction

        // Bounds are checked on 32 bits, so the pool end never wraps
        function bit pool_offset(int unsigned frame, output int unsigned ofs);
            int unsigned first;
            first = base_frame;
            ofs   = 0;
            if (frame < first)
                return 1'b0;
            if (frame - first >= live_groups() * 8)
                return 1'b0;
            ofs = frame - first;
            return 1'b1;
        endfunction

        function void set_register(logic index, logic [FRAME_W-1:0] data);
            if (index == CFG_BASE)
                base_frame = data;
            else
                pool_groups = data[GROUPS_W-1:0];
        endfunction

        // Apply one accepted item to the shadow pool and queue the result it owes
        function void note_request(logic [OP_W-1:0] req_op, logic [FRAME_W-1:0] frame,
                                   logic [COUNT_W-1:0] n);
            frame_result_t r;
            int unsigned   ofs;
            int unsigned   g;
            int unsigned   b;
            int unsigned   i;
            bit            found;
            r.frame  = '0;
            r.status = ST_OK;
            found    = 1'b0;
            case (req_op)
                OP_ALLOC:
                begin
                    r.status = ST_EMPTY;
                    for (g = 0; g < live_groups() && !found; g++) begin
                        if (used_map[g] != BYTE_FULL) begin
                            b = 0;
                            while (b < 7 && used_map[g][b])
                                b++;
                            used_map[g][b] = 1'b1;
                            // Frame number wraps at 20 bits
                            r.frame  = FRAME_W'(base_frame + g * 8 + b);
                            r.status = ST_OK;
                            found    = 1'b1;
                        end
                    end
                end
                OP_RELEASE:
                begin
                    if (pool_offset(frame, ofs))
                        used_map[ofs / 8][ofs % 8] = 1'b0;
                    else
                        r.status = ST_OUTSIDE;
                end
                OP_MARK:
                begin
                    for (i = 0; i < n; i++) begin
                        if (pool_offset(int'(frame) + i, ofs))
                            used_map[ofs / 8][ofs % 8] = 1'b1;
                        else
                            r.status = ST_OUTSIDE;
                    end
                end
                default:
                begin
                end
            endcase
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < REPORT_LIMIT)
                $display("%0t ns: error: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [FRAME_W-1:0] got_frame, logic [STATUS_W-1:0] got_status);
            frame_result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result frame %h status %0d with no request pending",
                                          got_frame, got_status));
            end
            else begin
                want = expected_results.pop_front();
                if (got_frame !== want.frame)
                    report_mismatch($sformatf("frame_no_out %h, predicted %h",
                                              got_frame, want.frame));
                if (got_status !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              got_status, want.status));
            end
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_index = 1'b0;
    logic [FRAME_W-1:0]  cfg_data = '0;
    logic                in_valid = 1'b0;
    logic [OP_W-1:0]     op = '0;
    logic [FRAME_W-1:0]  frame_no = '0;
    logic [COUNT_W-1:0]  count = '0;
    logic                out_ready = 1'b0;
    wire                 cfg_ready;
    wire                 in_ready;
    wire                 out_valid;
    wire [FRAME_W-1:0]   frame_no_out;
    wire [STATUS_W-1:0]  status;

    frame_pool_scoreboard frame_book;

    int unsigned ready_mode = 0;
    int unsigned mode_left = 0;

    bitmap_frame_allocator_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .frame_no     (frame_no),
        .count        (count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_no_out (frame_no_out),
        .status       (status)
    );

    always #4 clk = ~clk;

    // Receiver: switch between stall patterns after a random stretch,
    // from always ready down to mostly stalled
    always @(negedge clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 400);
        end
        else begin
            mode_left--;
        end
        case (ready_mode)
            0: out_ready = 1'b1;
            1: out_ready = ($urandom_range(0, 3) != 0);
            2: out_ready = ($urandom_range(0, 1) == 0);
            default: out_ready = ($urandom_range(0, 4) == 0);
        endcase
    end

    // Compare every accepted result against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            frame_book.check_result(frame_no_out, status);
    end

    // Present one item at the falling edge and hold it until accepted.
    // Valid stays high afterwards; the caller drops it with idle_gap if needed.
    task send_request(input logic [OP_W-1:0] req_op, input logic [FRAME_W-1:0] req_frame,
                      input logic [COUNT_W-1:0] req_count);
        @(negedge clk);
        in_valid = 1'b1;
        op       = req_op;
        frame_no = req_frame;
        count    = req_count;
        do
            @(posedge clk);
        while (!in_ready);
        frame_book.note_request(req_op, req_frame, req_count);
    endtask

    task idle_gap(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    // Stop sending and hold until the block has returned every owed result
    task wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (frame_book.expected_results.size() != 0)
            @(negedge clk);
    endtask

    task write_register(input logic index, input logic [FRAME_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        frame_book.set_register(index, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly frames inside the pool, some on its edges, the rest anywhere
    function automatic logic [FRAME_W-1:0] pick_frame();
        int unsigned span;
        int unsigned first;
        int unsigned pick;
        span  = frame_book.live_groups() * 8;
        first = frame_book.base_frame;
        pick  = $urandom_range(0, 99);
        if (pick < 70 && span > 0)
            return FRAME_W'(first + $urandom_range(0, span - 1));
        if (pick < 85) begin
            case ($urandom_range(0, 3))
                0: return FRAME_W'(first - 1);
                1: return FRAME_W'(first);
                2: return FRAME_W'(first + span);
                default: return FRAME_W'(first + span - 1);
            endcase
        end
        return FRAME_W'($urandom());
    endfunction

    // Keep most runs short; long runs are slow, so only a few go to the limit
    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned span;
        int unsigned pick;
        span = frame_book.live_groups() * 8 + 8;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return COUNT_W'($urandom_range(0, 16));
        if (pick < 95)
            return COUNT_W'($urandom_range(0, (span > 4096) ? 4096 : span));
        if (pick < 98)
            return COUNT_W'($urandom_range(0, 4096));
        return COUNT_W'(4096);
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            return OP_ALLOC;
        if (pick < 68)
            return OP_RELEASE;
        if (pick < 97)
            return OP_MARK;
        return OP_UNUSED;
    endfunction

    initial begin
        int                 phase;
        int                 k;
        int                 burst_left;
        logic [FRAME_W-1:0] base_pick;
        logic [FRAME_W-1:0] groups_pick;

        frame_book = new();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Pool at the top of the frame space: allocation wraps, mark straddles the base
        wait_drain();
        write_register(CFG_BASE, 20'hFFFFF);
        write_register(CFG_GROUPS, 20'd1);
        send_request(OP_ALLOC, 20'h0, 13'd0);
        send_request(OP_ALLOC, 20'h0, 13'd0);
        send_request(OP_RELEASE, 20'hFFFFF, 13'd0);
        send_request(OP_RELEASE, 20'h00000, 13'd0);
        send_request(OP_MARK, 20'hFFFFE, 13'd3);

        // Oversized group count: fill the whole map, then probe its last frame and past it
        wait_drain();
        write_register(CFG_BASE, 20'h0);
        write_register(CFG_GROUPS, 20'd1023);
        send_request(OP_MARK, 20'h0, 13'd0);
        send_request(OP_MARK, 20'h0, 13'd4096);
        send_request(OP_ALLOC, 20'h0, 13'd0);
        send_request(OP_RELEASE, 20'd4095, 13'd0);
        send_request(OP_RELEASE, 20'd4096, 13'd0);
        send_request(OP_ALLOC, 20'h0, 13'd0);
        send_request(OP_RELEASE, 20'hFFFFF, 13'd0);
        send_request(OP_MARK, 20'hFFFFF, 13'd4096);
        send_request(OP_UNUSED, 20'h5A5A5, 13'd4095);

        // Empty pool: nothing to allocate, every frame outside
        wait_drain();
        write_register(CFG_GROUPS, 20'd0);
        send_request(OP_ALLOC, 20'h0, 13'd0);
        send_request(OP_RELEASE, 20'h0, 13'd0);
        send_request(OP_MARK, 20'h0, 13'd1);
        send_request(OP_MARK, 20'd5, 13'd0);

        // Shifted base over the old bitmap: bits keep their positions
        wait_drain();
        write_register(CFG_BASE, 20'd8);
        write_register(CFG_GROUPS, 20'd512);
        send_request(OP_RELEASE, 20'd8, 13'd0);
        send_request(OP_ALLOC, 20'h0, 13'd0);
        send_request(OP_RELEASE, 20'd7, 13'd0);

        // Random phases, each under its own pool setting
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:  begin base_pick = 20'h0;                   groups_pick = 20'd2;    end
                1:  begin base_pick = FRAME_W'($urandom());    groups_pick = 20'd16;   end
                2:  begin base_pick = 20'hFFFFC;               groups_pick = 20'd1;    end
                3:  begin base_pick = FRAME_W'($urandom_range(0, 64)); groups_pick = 20'd64; end
                4:  begin base_pick = 20'h0;                   groups_pick = 20'd512;  end
                5:  begin base_pick = FRAME_W'($urandom());    groups_pick = 20'd0;    end
                6:  begin base_pick = 20'hFFFFF;               groups_pick = 20'd1023; end
                7:  begin base_pick = FRAME_W'($urandom());    groups_pick = FRAME_W'($urandom()); end
                8:  begin base_pick = 20'h80000;               groups_pick = 20'd4;    end
                9:
                begin
                    base_pick   = FRAME_W'($urandom());
                    groups_pick = FRAME_W'($urandom_range(1, 600));
                end
                10: begin base_pick = FRAME_W'($urandom());    groups_pick = 20'd8;    end
                default: begin base_pick = 20'h0;              groups_pick = 20'd1;    end
            endcase
            wait_drain();
            write_register(CFG_BASE, base_pick);
            write_register(CFG_GROUPS, groups_pick);

            burst_left = $urandom_range(1, 24);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                send_request(pick_op(), pick_frame(), pick_count());
                // In phase 3, hold off once mid-phase until every result is back
                if (phase == 3 && k == PHASE_ITEMS / 2)
                    wait_drain();
                // Every fourth phase streams with no sender gaps at all
                if (phase % 4 != 2) begin
                    burst_left--;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 2) != 0)
                            idle_gap($urandom_range(1, 12));
                        burst_left = $urandom_range(1, 24);
                    end
                end
            end
        end

        // Drain, then give the block time for any stray result
        wait_drain();
        repeat (16) @(negedge clk);
        if (frame_book.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #250_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
